// ----- design/rc4v_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 variable-length keystream package
// Field widths, operation codes and controller state type shared by the block.
// ----------------------------------------------------------------------------
package rc4v_pkg;

    localparam int OP_W        = 2;
    localparam int KEY_INDEX_W = 9;
    localparam int BYTE_W      = 8;
    localparam int KEY_LEN_W   = 10;

    localparam logic [OP_W-1:0] OP_LOAD_KEY = 2'd0;
    localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd1;
    localparam logic [OP_W-1:0] OP_DATA     = 2'd2;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 10'd256;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_MIX_RD,
        ST_MIX_MOD,
        ST_MIX_WAIT,
        ST_MIX_SWAP,
        ST_MIX_WR,
        ST_DAT_I,
        ST_DAT_SA,
        ST_DAT_J,
        ST_DAT_SB,
        ST_DAT_WR,
        ST_DAT_T,
        ST_DAT_OUT
    } rc4v_state_t;

endpackage
`default_nettype wire

// ----- design/rc4v_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 request channel
// Valid/ready channel carrying one request: operation, key index and byte.
// ----------------------------------------------------------------------------
interface rc4v_req_if import rc4v_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        op;
    logic [KEY_INDEX_W-1:0] key_index;
    logic [BYTE_W-1:0]      value;

    modport source (output valid, output op, output key_index, output value, input ready);
    modport sink   (input valid, input op, input key_index, input value, output ready);

endinterface
`default_nettype wire

// ----- design/rc4v_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 result channel
// Valid/ready channel carrying one processed data byte.
// ----------------------------------------------------------------------------
interface rc4v_rsp_if import rc4v_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);

endinterface
`default_nettype wire

// ----- design/rc4v_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 generic RAM
// Single write port, single read port, registered read data held when idle.
// ----------------------------------------------------------------------------
module rc4v_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- design/rc4v_mod.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 remainder unit
// Reduces a small sum modulo n. Sums below 2n are reduced directly; larger
// ones go through a restoring bit-serial pass, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rc4v_mod #(
    parameter int DW = 10,
    parameter int NW = 10,
    parameter int AW = 9
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [NW-1:0] divisor,
    output logic               busy,
    output logic      [AW-1:0] remainder
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] count_reg, count_next;
    logic [DW-1:0] shift_reg, shift_next;
    logic [NW-1:0] rem_reg, rem_next;

    logic [DW-1:0] div_wide;
    logic [DW-1:0] diff;
    logic [NW:0]   trial;
    logic [NW:0]   div_ext;
    logic [NW:0]   trial_sub;

    always_comb
    begin
        div_wide   = DW'(divisor);
        diff       = dividend - div_wide;
        div_ext    = {1'b0, divisor};
        trial      = {rem_reg, shift_reg[DW-1]};
        trial_sub  = trial - div_ext;
        busy_next  = busy_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            if (dividend < div_wide)
            begin
                rem_next = dividend[NW-1:0];
            end
            else if (diff < div_wide)
            begin
                rem_next = diff[NW-1:0];
            end
            else
            begin
                busy_next  = 1'b1;
                count_next = CW'(DW);
                shift_next = dividend;
                rem_next   = '0;
            end
        end
        else if (busy_reg)
        begin
            rem_next   = (trial >= div_ext) ? trial_sub[NW-1:0] : trial[NW-1:0];
            shift_next = {shift_reg[DW-2:0], 1'b0};
            count_next = count_reg - CW'(1);
            if (count_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg[AW-1:0];

endmodule
`default_nettype wire

// ----- design/rc4_variable_length_keystream.sv -----
`default_nettype none
// Sequencing: a key load is written from IDLE; a data byte reduces its three
// remainders (i+1, j+S[i], S[i]+S[j] mod n), each directly when below 2n and
// bit-serially otherwise. A schedule fills n entries, then mixes each entry in
// turn, with a bit-serial pass for each slow remainder. The block takes one request at a
// time, set by the single port pair of the permutation RAM and the remainder unit.
// Reset: indices cleared, length set to 256; RAM contents are undefined until written.
// ----------------------------------------------------------------------------
// RC4 variable-length keystream
// Key store, permutation RAM, shared remainder unit and the sequencing FSM.
// ----------------------------------------------------------------------------
module rc4_variable_length_keystream import rc4v_pkg::*; #(
    parameter int MAX_KEY_LEN = 512
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    rc4v_req_if.sink                  req,
    rc4v_rsp_if.source                rsp,
    input  wire logic                 cfg_we,
    input  wire logic [KEY_LEN_W-1:0] cfg_wdata
);

    localparam int AW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int NW = $clog2(MAX_KEY_LEN + 1);
    localparam int DW = $clog2(MAX_KEY_LEN + 511);
    localparam logic [31:0] MAX_LEN_U = 32'(MAX_KEY_LEN);

    rc4v_state_t state_reg, state_next;

    logic [KEY_LEN_W-1:0] key_length_reg, key_length_next;
    logic [AW-1:0]        cnt_reg, cnt_next;
    logic [AW-1:0]        a_reg, a_next;
    logic [AW-1:0]        b_reg, b_next;
    logic [AW-1:0]        i_reg, i_next;
    logic [AW-1:0]        j_reg, j_next;
    logic [BYTE_W-1:0]    sa_reg, sa_next;
    logic [BYTE_W-1:0]    value_reg, value_next;
    logic [BYTE_W-1:0]    data_out_reg, data_out_next;
    logic                 out_valid_reg, out_valid_next;

    logic [NW-1:0] n_eff;
    logic [NW-1:0] n_last;
    logic          cnt_last;

    logic              perm_we, perm_re;
    logic [AW-1:0]     perm_waddr, perm_raddr;
    logic [BYTE_W-1:0] perm_wdata, perm_rdata;
    logic              key_we, key_re;
    logic [AW-1:0]     key_waddr, key_raddr;
    logic [BYTE_W-1:0] key_wdata, key_rdata;

    logic          mod_start, mod_busy;
    logic [DW-1:0] mod_x;
    logic [AW-1:0] mod_rem;

    rc4v_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_KEY_LEN), .ADDR_W(AW)) u_perm_ram (
        .clk   (clk),
        .we    (perm_we),
        .waddr (perm_waddr),
        .wdata (perm_wdata),
        .re    (perm_re),
        .raddr (perm_raddr),
        .rdata (perm_rdata)
    );

    rc4v_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_KEY_LEN), .ADDR_W(AW)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    rc4v_mod #(.DW(DW), .NW(NW), .AW(AW)) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_x),
        .divisor   (n_eff),
        .busy      (mod_busy),
        .remainder (mod_rem)
    );

    // The modulus is the programmed length saturated into 1..MAX_KEY_LEN.
    always_comb
    begin
        if (key_length_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(key_length_reg) > MAX_LEN_U)
        begin
            n_eff = NW'(MAX_KEY_LEN);
        end
        else
        begin
            n_eff = NW'(key_length_reg);
        end
    end

    assign n_last   = n_eff - NW'(1);
    assign cnt_last = (NW'(cnt_reg) == n_last);

    always_comb
    begin
        state_next      = state_reg;
        key_length_next = cfg_we ? cfg_wdata : key_length_reg;
        cnt_next        = cnt_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        sa_next         = sa_reg;
        value_next      = value_reg;
        data_out_next   = data_out_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;

        perm_we    = 1'b0;
        perm_waddr = '0;
        perm_wdata = '0;
        perm_re    = 1'b0;
        perm_raddr = '0;
        key_we     = 1'b0;
        key_waddr  = AW'(req.key_index);
        key_wdata  = req.value;
        key_re     = 1'b0;
        key_raddr  = cnt_reg;
        mod_start  = 1'b0;
        mod_x      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.op)
                        OP_LOAD_KEY:
                        begin
                            key_we = (32'(req.key_index) < MAX_LEN_U);
                        end
                        OP_SCHEDULE:
                        begin
                            cnt_next   = '0;
                            b_next     = '0;
                            state_next = ST_FILL;
                        end
                        OP_DATA:
                        begin
                            value_next = req.value;
                            mod_start  = 1'b1;
                            mod_x      = DW'(i_reg) + DW'(1'b1);
                            state_next = ST_DAT_I;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                perm_we    = 1'b1;
                perm_waddr = cnt_reg;
                perm_wdata = BYTE_W'(cnt_reg);
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_MIX_RD;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_MIX_RD:
            begin
                perm_re    = 1'b1;
                perm_raddr = cnt_reg;
                key_re     = 1'b1;
                state_next = ST_MIX_MOD;
            end
            ST_MIX_MOD:
            begin
                sa_next    = perm_rdata;
                mod_start  = 1'b1;
                mod_x      = DW'(b_reg) + DW'(perm_rdata) + DW'(key_rdata);
                state_next = ST_MIX_WAIT;
            end
            ST_MIX_WAIT:
            begin
                if (!mod_busy)
                begin
                    b_next     = mod_rem;
                    perm_re    = 1'b1;
                    perm_raddr = mod_rem;
                    state_next = ST_MIX_SWAP;
                end
            end
            ST_MIX_SWAP:
            begin
                perm_we    = 1'b1;
                perm_waddr = cnt_reg;
                perm_wdata = perm_rdata;
                state_next = ST_MIX_WR;
            end
            ST_MIX_WR:
            begin
                perm_we    = 1'b1;
                perm_waddr = b_reg;
                perm_wdata = sa_reg;
                if (cnt_last)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + AW'(1);
                    state_next = ST_MIX_RD;
                end
            end
            ST_DAT_I:
            begin
                if (!mod_busy)
                begin
                    a_next     = mod_rem;
                    perm_re    = 1'b1;
                    perm_raddr = mod_rem;
                    state_next = ST_DAT_SA;
                end
            end
            ST_DAT_SA:
            begin
                sa_next    = perm_rdata;
                mod_start  = 1'b1;
                mod_x      = DW'(j_reg) + DW'(perm_rdata);
                state_next = ST_DAT_J;
            end
            ST_DAT_J:
            begin
                if (!mod_busy)
                begin
                    b_next     = mod_rem;
                    perm_re    = 1'b1;
                    perm_raddr = mod_rem;
                    state_next = ST_DAT_SB;
                end
            end
            ST_DAT_SB:
            begin
                // The swap leaves the sum of the two entries unchanged, so the
                // output index can be reduced while the write-back proceeds.
                perm_we    = 1'b1;
                perm_waddr = a_reg;
                perm_wdata = perm_rdata;
                mod_start  = 1'b1;
                mod_x      = DW'(sa_reg) + DW'(perm_rdata);
                state_next = ST_DAT_WR;
            end
            ST_DAT_WR:
            begin
                perm_we    = 1'b1;
                perm_waddr = b_reg;
                perm_wdata = sa_reg;
                state_next = ST_DAT_T;
            end
            ST_DAT_T:
            begin
                if (!mod_busy)
                begin
                    perm_re    = 1'b1;
                    perm_raddr = mod_rem;
                    state_next = ST_DAT_OUT;
                end
            end
            ST_DAT_OUT:
            begin
                // The RAM holds its read data, so a stalled output just waits here.
                if (!out_valid_reg || rsp.ready)
                begin
                    data_out_next  = value_reg ^ perm_rdata;
                    out_valid_next = 1'b1;
                    i_next         = a_reg;
                    j_next         = b_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            key_length_reg <= KEY_LEN_RESET;
            cnt_reg        <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            key_length_reg <= key_length_next;
            cnt_reg        <= cnt_next;
            a_reg          <= a_next;
            b_reg          <= b_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg       <= sa_next;
        value_reg    <= value_next;
        data_out_reg <= data_out_next;
    end

    assign req.ready    = (state_reg == ST_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.data_out = data_out_reg;

endmodule
`default_nettype wire
